/* hw/rtl/eth_ipv4_tcp_header_parser_assert.svh */
// Assertion macros shared by the parser modules.
`ifndef ETH_IPV4_TCP_HEADER_PARSER_ASSERT_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define EITP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed in header parser");

// Check a property on every edge, reset included.
`define EITP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed in header parser");

`else

`define EITP_ASSERT(label, clk, rst, prop)
`define EITP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* hw/rtl/eitp_pkg.sv */
`timescale 1ns / 1ps

package eitp_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT_ETH = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_SHORT_IP  = 3'd3;
  localparam logic [2:0] ST_NOT_TCP   = 3'd4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam int POS_TYPE_HI  = 12;
  localparam int POS_TYPE_LO  = 13;
  localparam int POS_IHL      = 14;
  localparam int POS_TOTAL_HI = 16;
  localparam int POS_TOTAL_LO = 17;
  localparam int POS_PROTO    = 23;

  localparam int ETH_HDR_BYTES = 14;
  localparam int MIN_IP_FRAME  = 34;
  localparam int TCP_CAP_BYTES = 16;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [5:0]  ip_hlen;
    logic [7:0]  ip_proto;
    logic [15:0] ip_total;
    logic [31:0] ports;
    logic [63:0] seq_ack;
    logic [5:0]  tcp_hlen;
    logic [7:0]  flags;
    logic [15:0] window;
  } frame_hdr_t;

endpackage

/* hw/rtl/eitp_in_if.sv */
`timescale 1ns / 1ps

interface eitp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

/* hw/rtl/eitp_out_if.sv */
`timescale 1ns / 1ps

interface eitp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [15:0] window_size;
  logic [7:0]  tcp_flag_bits;
  logic [15:0] payload_len;
  logic [11:0] frame_length;

  modport source (output valid, status, source_port, dest_port, seq_number, ack_number,
                  window_size, tcp_flag_bits, payload_len, frame_length, input ready);
  modport sink (input valid, status, source_port, dest_port, seq_number, ack_number,
                window_size, tcp_flag_bits, payload_len, frame_length, output ready);
endinterface

/* hw/rtl/eitp_capture.sv */
`timescale 1ns / 1ps
`include "eth_ipv4_tcp_header_parser_assert.svh"

module eitp_capture #(
  parameter int MAX_FRAME_BYTES = 2048,
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  eitp_in_if.sink                 ingress,
  output logic                    fin_valid,
  input  logic                    fin_ready,
  output eitp_pkg::frame_hdr_t    fin_hdr,
  output logic [CW-1:0]           fin_len
);
  import eitp_pkg::*;

  logic          s1_valid;
  logic          s1_last;
  logic [7:0]    s1_byte;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  frame_hdr_t    hdr;
  frame_hdr_t    hdr_next;
  logic          take;
  logic [5:0]    hlen_eff;
  logic [CW-1:0] tcp_start;
  logic          in_tcp;
  logic [3:0]    k;
  logic [2:0]    j;

  always_comb begin
    hdr_next  = hdr;
    idx_next  = idx;
    hlen_eff  = hdr.ip_hlen;
    tcp_start = '0;
    in_tcp    = 1'b0;
    k         = '0;
    j         = '0;
    if (idx < CW'(MAX_FRAME_BYTES)) begin
      idx_next = idx + 1'b1;
      if (idx == CW'(POS_TYPE_HI))  hdr_next.ether_type[15:8] = s1_byte;
      if (idx == CW'(POS_TYPE_LO))  hdr_next.ether_type[7:0]  = s1_byte;
      if (idx == CW'(POS_TOTAL_HI)) hdr_next.ip_total[15:8]   = s1_byte;
      if (idx == CW'(POS_TOTAL_LO)) hdr_next.ip_total[7:0]    = s1_byte;
      if (idx == CW'(POS_PROTO))    hdr_next.ip_proto         = s1_byte;
      if (idx == CW'(POS_IHL)) begin
        hlen_eff         = {s1_byte[3:0], 2'b00};
        hdr_next.ip_hlen = hlen_eff;
      end
      tcp_start = CW'(POS_IHL) + CW'(hlen_eff);
      in_tcp    = (idx >= tcp_start) && (idx < tcp_start + CW'(TCP_CAP_BYTES));
      k         = 4'(idx - tcp_start);
      j         = 3'(k - 4'd4);
      if (in_tcp) begin
        if (k < 4'd4) begin
          hdr_next.ports[{~k[1:0], 3'b000} +: 8] = s1_byte;
        end else if (k < 4'd12) begin
          hdr_next.seq_ack[{~j, 3'b000} +: 8] = s1_byte;
        end else begin
          case (k)
            4'd12:   hdr_next.tcp_hlen     = {s1_byte[7:4], 2'b00};
            4'd13:   hdr_next.flags        = s1_byte;
            4'd14:   hdr_next.window[15:8] = s1_byte;
            default: hdr_next.window[7:0]  = s1_byte;
          endcase
        end
      end
    end
  end

  assign take          = s1_valid && (!s1_last || fin_ready);
  assign ingress.ready = !s1_valid || take;
  assign fin_valid     = s1_valid && s1_last;
  assign fin_hdr       = hdr_next;
  assign fin_len       = idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      idx      <= '0;
      hdr      <= '0;
    end else begin
      if (ingress.ready) s1_valid <= ingress.valid;
      if (take) begin
        idx <= s1_last ? '0 : idx_next;
        hdr <= s1_last ? '0 : hdr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ingress.valid && ingress.ready) begin
      s1_byte <= ingress.data_byte;
      s1_last <= ingress.last_byte;
    end
  end

  `EITP_ASSERT(a_idx_saturates, clk, rst, idx <= CW'(MAX_FRAME_BYTES))
  `EITP_ASSERT(a_clear_after_last, clk, rst, (take && s1_last) |=> (idx == '0 && hdr == '0))
  `EITP_ASSERT(a_hold_stalled, clk, rst, (s1_valid && !take) |=> (s1_valid && s1_last && $stable(s1_byte)))

endmodule

/* hw/rtl/eitp_result.sv */
`timescale 1ns / 1ps
`include "eth_ipv4_tcp_header_parser_assert.svh"

module eitp_result #(
  parameter int MAX_FRAME_BYTES = 2048,
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fin_valid,
  output logic                    fin_ready,
  input  eitp_pkg::frame_hdr_t    fin_hdr,
  input  logic [CW-1:0]           fin_len,
  eitp_out_if.source              egress
);
  import eitp_pkg::*;

  logic [2:0]  status_c;
  logic [6:0]  hdrs;
  logic [15:0] payload_c;
  logic        ok;

  always_comb begin
    if (fin_len < CW'(ETH_HDR_BYTES)) begin
      status_c = ST_SHORT_ETH;
    end else if (fin_hdr.ether_type != ETHERTYPE_IPV4) begin
      status_c = ST_NOT_IPV4;
    end else if (fin_len < CW'(MIN_IP_FRAME)) begin
      status_c = ST_SHORT_IP;
    end else if (fin_hdr.ip_proto != PROTO_TCP ||
                 fin_len < CW'(MIN_IP_FRAME) + CW'(fin_hdr.ip_hlen)) begin
      status_c = ST_NOT_TCP;
    end else begin
      status_c = ST_OK;
    end
  end

  assign ok        = (status_c == ST_OK);
  assign hdrs      = {1'b0, fin_hdr.ip_hlen} + {1'b0, fin_hdr.tcp_hlen};
  assign payload_c = (fin_hdr.ip_total > 16'(hdrs)) ? fin_hdr.ip_total - 16'(hdrs) : '0;
  assign fin_ready = !egress.valid || egress.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      egress.valid <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      egress.valid <= 1'b1;
    end else if (egress.ready) begin
      egress.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      egress.status        <= status_c;
      egress.source_port   <= ok ? fin_hdr.ports[31:16]   : '0;
      egress.dest_port     <= ok ? fin_hdr.ports[15:0]    : '0;
      egress.seq_number    <= ok ? fin_hdr.seq_ack[63:32] : '0;
      egress.ack_number    <= ok ? fin_hdr.seq_ack[31:0]  : '0;
      egress.window_size   <= ok ? fin_hdr.window         : '0;
      egress.tcp_flag_bits <= ok ? fin_hdr.flags          : '0;
      egress.payload_len   <= ok ? payload_c              : '0;
      egress.frame_length  <= 12'(fin_len);
    end
  end

  `EITP_ASSERT(a_fields_zero, clk, rst, (egress.valid && egress.status != ST_OK) |-> (egress.source_port == '0 && egress.dest_port == '0 && egress.seq_number == '0 && egress.ack_number == '0 && egress.window_size == '0 && egress.tcp_flag_bits == '0 && egress.payload_len == '0))
  `EITP_ASSERT_ALWAYS(a_idle_after_reset, clk, $past(rst) |-> !egress.valid)
  `EITP_ASSERT(a_load_shows, clk, rst, (fin_valid && fin_ready) |=> egress.valid)

endmodule

/* hw/rtl/eth_ipv4_tcp_header_parser.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                                        Handshake
// ingress   in   data_byte, last_byte                           valid / ready
// egress    out  status, ports, seq, ack, window, flags,        valid / ready
//                payload_len, frame_length
//
// One byte is accepted per cycle while ingress ready is high; each byte passes through the input register.
// The last byte of a frame passes through the input register, and the frame's result is then registered at egress.
// Synchronous reset clears the byte count and all captured headers; no clearing pass.
// While a result waits on egress, bytes keep flowing until the next last byte,
// which then holds in the input register and drops ingress ready.

module eth_ipv4_tcp_header_parser #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  eitp_in_if.sink     ingress,
  eitp_out_if.source  egress
);
  import eitp_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic          fin_valid;
  logic          fin_ready;
  frame_hdr_t    fin_hdr;
  logic [CW-1:0] fin_len;

  eitp_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .ingress   (ingress),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_hdr   (fin_hdr),
    .fin_len   (fin_len)
  );

  eitp_result #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_hdr   (fin_hdr),
    .fin_len   (fin_len),
    .egress    (egress)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import eitp_pkg::*;

  localparam int MAX_BYTES    = 2048;
  localparam int TCP_MIN_HDR  = 20;
  localparam int RANDOM_BYTES = 350;
  localparam int MIN_FRAMES   = 5;
  localparam int HOLD_CYCLES  = 500;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] window_size;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] payload_len;
    logic [11:0] frame_length;
  } hdr_result_t;

  logic clk = 1'b0;
  logic rst;

  eitp_in_if  in_if ();
  eitp_out_if out_if ();

  eth_ipv4_tcp_header_parser #(.MAX_FRAME_BYTES(MAX_BYTES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .ingress (in_if),
    .egress  (out_if)
  );

  always #5 clk = ~clk;

  frame_hdr_t  cur_hdr;
  int          cur_len;
  hdr_result_t pending_results[$];
  hdr_result_t want;
  logic [7:0]  frame_bytes[$];
  int          err_count;
  int          bytes_sent;
  int          frames_done;
  int          stall_cycles;
  int          hold_left;
  int          hold_count;
  int          hold_seen;
  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;

  task automatic parse_byte(input logic [7:0] b, input logic l);
    int tcp_base;
    int k;
    int hdrs;
    hdr_result_t r;
    if (cur_len < MAX_BYTES) begin
      case (cur_len)
        POS_TYPE_HI:  cur_hdr.ether_type[15:8] = b;
        POS_TYPE_LO:  cur_hdr.ether_type[7:0] = b;
        POS_IHL:      cur_hdr.ip_hlen = {b[3:0], 2'b00};
        POS_TOTAL_HI: cur_hdr.ip_total[15:8] = b;
        POS_TOTAL_LO: cur_hdr.ip_total[7:0] = b;
        POS_PROTO:    cur_hdr.ip_proto = b;
        default: ;
      endcase
      tcp_base = ETH_HDR_BYTES + int'(cur_hdr.ip_hlen);
      if (cur_len >= tcp_base && cur_len < tcp_base + TCP_CAP_BYTES) begin
        k = cur_len - tcp_base;
        if (k < 4) cur_hdr.ports[(3 - k) * 8 +: 8] = b;
        else if (k < 12) cur_hdr.seq_ack[(11 - k) * 8 +: 8] = b;
        else if (k == 12) cur_hdr.tcp_hlen = {b[7:4], 2'b00};
        else if (k == 13) cur_hdr.flags = b;
        else if (k == 14) cur_hdr.window[15:8] = b;
        else cur_hdr.window[7:0] = b;
      end
      cur_len++;
    end
    if (l) begin
      r = '0;
      if (cur_len < ETH_HDR_BYTES) r.status = ST_SHORT_ETH;
      else if (cur_hdr.ether_type != ETHERTYPE_IPV4) r.status = ST_NOT_IPV4;
      else if (cur_len < MIN_IP_FRAME) r.status = ST_SHORT_IP;
      else if (cur_hdr.ip_proto != PROTO_TCP ||
               cur_len < ETH_HDR_BYTES + int'(cur_hdr.ip_hlen) + TCP_MIN_HDR)
        r.status = ST_NOT_TCP;
      else r.status = ST_OK;
      if (r.status == ST_OK) begin
        hdrs = int'(cur_hdr.ip_hlen) + int'(cur_hdr.tcp_hlen);
        r.source_port   = cur_hdr.ports[31:16];
        r.dest_port     = cur_hdr.ports[15:0];
        r.seq_number    = cur_hdr.seq_ack[63:32];
        r.ack_number    = cur_hdr.seq_ack[31:0];
        r.window_size   = cur_hdr.window;
        r.tcp_flag_bits = cur_hdr.flags;
        r.payload_len   = (int'(cur_hdr.ip_total) > hdrs) ?
                          16'(int'(cur_hdr.ip_total) - hdrs) : 16'd0;
      end
      r.frame_length = cur_len[11:0];
      pending_results.push_back(r);
      frames_done++;
      cur_hdr = '0;
      cur_len = 0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic l);
    while (in_idle_en && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    parse_byte(b, l);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic build_tcp(input int ihl, input int doff, input int pay);
    int tcp_base;
    int n;
    logic [15:0] tot;
    logic [7:0] tmp;
    tcp_base = ETH_HDR_BYTES + ihl * 4;
    n = tcp_base + ((doff * 4 > TCP_MIN_HDR) ? doff * 4 : TCP_MIN_HDR) + pay;
    tot = 16'(n - ETH_HDR_BYTES);
    frame_bytes.delete();
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(255)));
    tmp = frame_bytes[tcp_base + 12];
    frame_bytes[tcp_base + 12] = {doff[3:0], tmp[3:0]};
    frame_bytes[POS_TYPE_HI]  = ETHERTYPE_IPV4[15:8];
    frame_bytes[POS_TYPE_LO]  = ETHERTYPE_IPV4[7:0];
    frame_bytes[POS_IHL]      = {4'h4, ihl[3:0]};
    frame_bytes[POS_TOTAL_HI] = tot[15:8];
    frame_bytes[POS_TOTAL_LO] = tot[7:0];
    frame_bytes[POS_PROTO]    = PROTO_TCP;
  endtask

  task automatic cut_frame(input int n);
    while (frame_bytes.size() > n) frame_bytes.delete(frame_bytes.size() - 1);
  endtask

  task automatic random_frame();
    int pick;
    int ihl;
    int doff;
    pick = $urandom_range(99);
    ihl  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5, 7);
    doff = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5, 8);
    build_tcp(ihl, doff, $urandom_range(16));
    if (pick < 60) begin
    end else if (pick < 68) begin
      frame_bytes[POS_TOTAL_HI] = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255));
      frame_bytes[POS_TOTAL_LO] = 8'($urandom_range(255));
    end else if (pick < 75) begin
      frame_bytes[POS_PROTO] = 8'($urandom_range(255));
    end else if (pick < 80) begin
      frame_bytes[POS_TYPE_HI] = 8'($urandom_range(255));
      frame_bytes[POS_TYPE_LO] = 8'($urandom_range(255));
    end else if (pick < 92) begin
      cut_frame($urandom_range(1, frame_bytes.size() - 1));
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom_range(255)));
    end
    send_frame();
  endtask

  task automatic test_short_frames();
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(255)));
    send_frame();
    build_tcp(5, 5, 0);
    cut_frame(ETH_HDR_BYTES - 1);
    send_frame();
    build_tcp(5, 5, 0);
    cut_frame(ETH_HDR_BYTES);
    send_frame();
    build_tcp(5, 5, 0);
    frame_bytes[POS_TYPE_LO] = 8'h01;
    cut_frame(ETH_HDR_BYTES);
    send_frame();
  endtask

  task automatic test_header_checks();
    build_tcp(5, 5, 4);
    cut_frame(MIN_IP_FRAME - 1);
    send_frame();
    build_tcp(5, 5, 4);
    cut_frame(MIN_IP_FRAME);
    send_frame();
    build_tcp(5, 5, 4);
    frame_bytes[POS_PROTO] = 8'd17;
    send_frame();
    build_tcp(5, 5, 4);
    frame_bytes[POS_TYPE_HI] = 8'h86;
    frame_bytes[POS_TYPE_LO] = 8'hdd;
    send_frame();
    build_tcp(5, 5, 0);
    send_frame();
  endtask

  task automatic test_field_extremes();
    build_tcp(15, 15, 4);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'hff;
    frame_bytes[POS_TYPE_HI] = ETHERTYPE_IPV4[15:8];
    frame_bytes[POS_TYPE_LO] = ETHERTYPE_IPV4[7:0];
    frame_bytes[POS_PROTO]   = PROTO_TCP;
    send_frame();
    build_tcp(5, 5, 0);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    frame_bytes[POS_TYPE_HI] = ETHERTYPE_IPV4[15:8];
    frame_bytes[POS_TYPE_LO] = ETHERTYPE_IPV4[7:0];
    frame_bytes[POS_IHL]     = 8'h05;
    frame_bytes[POS_PROTO]   = PROTO_TCP;
    frame_bytes[ETH_HDR_BYTES + TCP_MIN_HDR + 12] = 8'h50;
    send_frame();
    build_tcp(5, 5, 8);
    frame_bytes[POS_TOTAL_HI] = 8'h00;
    frame_bytes[POS_TOTAL_LO] = 8'h00;
    send_frame();
  endtask

  task automatic test_short_ip_header();
    build_tcp(0, 5, 2);
    send_frame();
    build_tcp(1, 6, 2);
    send_frame();
    build_tcp(4, 5, 0);
    send_frame();
  endtask

  task automatic test_back_to_back();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    repeat (10) random_frame();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_count++;
    repeat (12) begin
      frame_bytes.delete();
      repeat ($urandom_range(2, 6)) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame();
    end
    build_tcp(5, 5, 4);
    send_frame();
  endtask

  task automatic test_random();
    int start_bytes;
    int start_frames;
    start_bytes  = bytes_sent;
    start_frames = frames_done;
    while (bytes_sent - start_bytes < RANDOM_BYTES || frames_done - start_frames < MIN_FRAMES)
      random_frame();
  endtask

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %0h, got %0h", name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("result with none expected: status %0d, length %0d",
                   out_if.status, out_if.frame_length);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_if.status));
        check_field("source_port", 32'(want.source_port), 32'(out_if.source_port));
        check_field("dest_port", 32'(want.dest_port), 32'(out_if.dest_port));
        check_field("seq_number", want.seq_number, out_if.seq_number);
        check_field("ack_number", want.ack_number, out_if.ack_number);
        check_field("window_size", 32'(want.window_size), 32'(out_if.window_size));
        check_field("tcp_flag_bits", 32'(want.tcp_flag_bits), 32'(out_if.tcp_flag_bits));
        check_field("payload_len", 32'(want.payload_len), 32'(out_if.payload_len));
        check_field("frame_length", 32'(want.frame_length), 32'(out_if.frame_length));
      end
    end
  end

  // hold off the receiver for a long stretch on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count != hold_seen) begin
        hold_seen = hold_count;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= !(out_idle_en && $urandom_range(99) < 26);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cur_hdr         = '0;
    cur_len         = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_short_frames();
    test_header_checks();
    test_field_extremes();
    test_short_ip_header();
    test_back_to_back();
    test_backpressure();
    test_random();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/eitp_pkg.sv
hw/rtl/eitp_in_if.sv
hw/rtl/eitp_out_if.sv
hw/rtl/eitp_capture.sv
hw/rtl/eitp_result.sv
hw/rtl/eth_ipv4_tcp_header_parser.sv
verif/testbench.sv
